/* design/wcrs_pkg.sv */
// Shared types and constants for the weighted class ready scheduler.
package wcrs_pkg;

    // Class index field in a queued command, wide enough for the largest class count.
    localparam int CLS_W = 4;

    // Command queue between the front and back parts.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Requested priority that selects the host default.
    localparam logic signed [7:0] PRI_HOST_DEFAULT = -8'sd1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_GRANTED = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic               operation;
        logic [15:0]        conn_id;
        logic signed [7:0]  priority_req;
        logic               has_host;
        logic signed [7:0]  host_priority;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] out_conn_id;
        logic [1:0]  served_class;
    } result_t;

    typedef struct packed {
        logic             operation;
        logic [15:0]      conn_id;
        logic [CLS_W-1:0] cls;
    } cmd_t;

endpackage

/* design/weighted_class_ready_scheduler_top.sv */
// Top level of the weighted class ready scheduler.
// A request is taken when start is high and busy is low; busy rises only when the
// two-entry command queue in front of the execution unit is full. The execution
// unit takes the next command from that queue only once it has finished the last.
// A push goes through the push state to the result register. A pop scans one class
// per cycle; it reads the id of the first class that may serve and reports it as
// granted, or reports empty once the scan has visited every class and come back to
// the start. Results come in request order, each on result for exactly one cycle
// with result_strobe high, and must be captured then. Class p takes p+1 grants per
// turn.
module weighted_class_ready_scheduler_top
    import wcrs_pkg::*;
#(
    parameter int CLASS_COUNT = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     result_strobe,
    output result_t  result
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    wcrs_front #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    wcrs_back #(
        .CLASS_COUNT (CLASS_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_take      (cmd_take),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

/* design/wcrs_front.sv */
// Front part: accepts requests, resolves the priority class and queues commands.
module wcrs_front
    import wcrs_pkg::*;
#(
    parameter int CLASS_COUNT = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     cmd_valid,
    input  logic     cmd_take,
    output cmd_t     cmd
);

    localparam logic signed [7:0] PRI_TOP = 8'(CLASS_COUNT - 1);

    logic signed [7:0]       pri_eff;
    logic [CLS_W-1:0]        cls;
    cmd_t                    q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0]   wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0]   wr_ptr_next;
    logic [CMDQ_PTR_W-1:0]   rd_ptr_reg;
    logic [CMDQ_PTR_W-1:0]   rd_ptr_next;
    logic [CMDQ_CNT_W-1:0]   cnt_reg;
    logic [CMDQ_CNT_W-1:0]   cnt_next;
    logic                    push;
    logic                    pop;

    // Resolve host default, then clamp into the class range.
    always_comb
    begin
        if (request.priority_req == PRI_HOST_DEFAULT && request.has_host)
        begin
            pri_eff = request.host_priority;
        end
        else
        begin
            pri_eff = request.priority_req;
        end
        if (pri_eff < 8'sd0)
        begin
            cls = '0;
        end
        else if (pri_eff > PRI_TOP)
        begin
            cls = CLS_W'(CLASS_COUNT - 1);
        end
        else
        begin
            cls = pri_eff[CLS_W-1:0];
        end
    end

    assign busy      = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = start && !busy;
    assign pop       = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                        : wr_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                        : rd_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CMDQ_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{operation: request.operation,
                                   conn_id:   request.conn_id,
                                   cls:       cls};
        end
    end

endmodule

/* design/wcrs_back.sv */
// Back part: class FIFOs, weighted round robin scan and result register.
module wcrs_back
    import wcrs_pkg::*;
#(
    parameter int CLASS_COUNT = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_take,
    input  cmd_t    cmd,
    output logic    result_strobe,
    output result_t result
);

    localparam int CW        = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int FW        = $clog2(QUEUE_DEPTH + 1);
    localparam int GW        = $clog2(CLASS_COUNT + 1);
    localparam int SW        = FW + 1;
    localparam int AW        = CW + PW;
    localparam int MEM_DEPTH = CLASS_COUNT * (1 << PW);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PUSH  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_GRANT = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CW-1:0]       cur_reg;
    logic [CW-1:0]       cur_next;
    logic [GW-1:0]       grants_reg;
    logic [GW-1:0]       grants_next;
    logic [GW-1:0]       scan_cnt_reg;
    logic [GW-1:0]       scan_cnt_next;
    logic [CW-1:0]       gcls_reg;
    logic [CW-1:0]       gcls_next;
    cmd_t                cmd_reg;
    logic [PW-1:0]       heads_reg [CLASS_COUNT];
    logic [FW-1:0]       fill_reg [CLASS_COUNT];
    logic [ID_WIDTH-1:0] mem [MEM_DEPTH];
    logic [ID_WIDTH-1:0] rdata_reg;
    result_t             res_reg;
    result_t             res_next;
    logic                res_valid_reg;
    logic                res_valid_next;

    logic [CW-1:0]       sel;
    logic [FW-1:0]       fill_sel;
    logic [PW-1:0]       head_sel;
    logic [SW-1:0]       tail_sum;
    logic [PW-1:0]       tail;
    logic [PW-1:0]       head_inc;
    logic [CW-1:0]       cur_inc;
    logic [AW-1:0]       mem_addr;
    logic                eligible;
    logic                full;
    logic                mem_we;
    logic                mem_re;
    logic                fill_we;
    logic [FW-1:0]       fill_new;
    logic                head_we;

    assign sel      = (state_reg == S_PUSH) ? cmd_reg.cls[CW-1:0] : cur_reg;
    assign fill_sel = fill_reg[sel];
    assign head_sel = heads_reg[sel];
    assign tail_sum = SW'(head_sel) + SW'(fill_sel);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                    : PW'(tail_sum);
    assign head_inc = (head_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + PW'(1);
    assign cur_inc  = (cur_reg == CW'(CLASS_COUNT - 1)) ? '0 : cur_reg + CW'(1);
    assign mem_addr = (state_reg == S_PUSH) ? {sel, tail} : {sel, head_sel};
    // A class may serve while its turn has grants left; a fresh turn always has.
    assign eligible = (fill_sel != '0) && (grants_reg <= GW'(cur_reg));
    assign full     = (fill_sel == FW'(QUEUE_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        grants_next    = grants_reg;
        scan_cnt_next  = scan_cnt_reg;
        gcls_next      = gcls_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        cmd_take       = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        fill_we        = 1'b0;
        fill_new       = fill_sel;
        head_we        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take      = 1'b1;
                    scan_cnt_next = '0;
                    state_next    = (cmd.operation == OP_POP) ? S_SCAN : S_PUSH;
                end
            end
            S_PUSH:
            begin
                res_valid_next        = 1'b1;
                res_next.out_conn_id  = '0;
                res_next.served_class = 2'(sel);
                if (full)
                begin
                    res_next.status = ST_DROPPED;
                end
                else
                begin
                    res_next.status = ST_PUSHED;
                    mem_we          = 1'b1;
                    fill_we         = 1'b1;
                    fill_new        = fill_sel + FW'(1);
                end
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (eligible)
                begin
                    mem_re      = 1'b1;
                    head_we     = 1'b1;
                    fill_we     = 1'b1;
                    fill_new    = fill_sel - FW'(1);
                    grants_next = grants_reg + GW'(1);
                    gcls_next   = cur_reg;
                    state_next  = S_GRANT;
                end
                else if (scan_cnt_reg == GW'(CLASS_COUNT))
                begin
                    // Every class visited and back at the start: report empty.
                    grants_next           = '0;
                    res_valid_next        = 1'b1;
                    res_next.status       = ST_EMPTY;
                    res_next.out_conn_id  = '0;
                    res_next.served_class = '0;
                    state_next            = S_IDLE;
                end
                else
                begin
                    cur_next      = cur_inc;
                    grants_next   = '0;
                    scan_cnt_next = scan_cnt_reg + GW'(1);
                end
            end
            S_GRANT:
            begin
                res_valid_next        = 1'b1;
                res_next.status       = ST_GRANTED;
                res_next.out_conn_id  = 16'(rdata_reg);
                res_next.served_class = 2'(gcls_reg);
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            grants_reg    <= '0;
            scan_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                heads_reg[i] <= '0;
                fill_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            grants_reg    <= grants_next;
            scan_cnt_reg  <= scan_cnt_next;
            res_valid_reg <= res_valid_next;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                if (fill_we && sel == CW'(i))
                begin
                    fill_reg[i] <= fill_new;
                end
                if (head_we && sel == CW'(i))
                begin
                    heads_reg[i] <= head_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gcls_reg <= gcls_next;
        res_reg  <= res_next;
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= ID_WIDTH'(cmd_reg.conn_id);
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign result_strobe = res_valid_reg;
    assign result        = res_reg;

`ifndef SYNTH
    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(state_reg == S_PUSH || state_reg == S_SCAN
                                || state_reg == S_GRANT))
        else $error("result strobe without a finishing command");

    a_grant_source: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_GRANTED) |-> $past(state_reg == S_GRANT))
        else $error("grant reported without a memory read");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_cnt_reg <= GW'(CLASS_COUNT)))
        else $error("scan ran past all classes");

    a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
        grants_reg <= GW'(CLASS_COUNT))
        else $error("grants in turn exceed the largest weight");

    a_take_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> (state_reg == S_PUSH || state_reg == S_SCAN))
        else $error("taken command not dispatched");
`endif

endmodule
